@@ rtl/bwlp_pkg.sv @@
package bwlp_pkg;

	// default sample width and fixed-point formats
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int DATA_W           = 32;
	localparam int COEF_W           = 32;
	localparam int COEF_FRAC        = 30;
	localparam int ACC_W            = 48;
	localparam int ACC_FRAC         = 16;
	localparam int PROD_W           = 64;
	localparam int SUM_W            = 52;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_S1_B0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_S1_A1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_S1_A2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_S2_B0  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_S2_A1  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_S2_A2  = 3'd6;

	// datapath operations, issued one per cycle by the sequencer
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_IDLE   = 3'd0;
	localparam logic [OP_W-1:0] OP_MUL_B0 = 3'd1;
	localparam logic [OP_W-1:0] OP_Y      = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL_A1 = 3'd3;
	localparam logic [OP_W-1:0] OP_N1     = 3'd4;
	localparam logic [OP_W-1:0] OP_MUL_A2 = 3'd5;
	localparam logic [OP_W-1:0] OP_N2     = 3'd6;

	typedef struct packed {
		logic            load;
		logic [OP_W-1:0] op;
		logic            sec;
		logic [1:0]      clr;
	} ctrl_t;

endpackage

@@ rtl/butterworth_lowpass_biquad_cascade_top.sv @@
// filtered items pass through section one then section two; bypassed items skip both
// in_stall stays high until the result reaches the output register: one item at a time
// one 32x32 multiplier is shared by all six products; each section takes six steps
// a stalled output holds the finished item; the next result waits in ST_DONE for it
// reset (arst_n low, asynchronous) clears control, configuration registers and all four accumulators
module butterworth_lowpass_biquad_cascade_top #(
	parameter int SAMPLE_WIDTH = bwlp_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bwlp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bwlp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]       sample_out
);
	import bwlp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]      state_q;
	logic [OP_W-1:0] step_q;
	logic            sec_q;
	logic            pass_q;
	logic            out_valid_q;
	logic            en_q;
	logic signed [COEF_W-1:0] b0_q [2];
	logic signed [COEF_W-1:0] a1_q [2];
	logic signed [COEF_W-1:0] a2_q [2];
	logic signed [SAMPLE_WIDTH-1:0] pass_sample_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

	logic in_acc;
	logic out_free;
	ctrl_t ctrl;
	logic signed [COEF_W-1:0] coef;
	logic signed [SAMPLE_WIDTH-1:0] dp_y;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			b0_q[0] <= '0;
			b0_q[1] <= '0;
			a1_q[0] <= '0;
			a1_q[1] <= '0;
			a2_q[0] <= '0;
			a2_q[1] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: en_q    <= cfg_data[0];
				REG_S1_B0:  b0_q[0] <= signed'(cfg_data);
				REG_S1_A1:  a1_q[0] <= signed'(cfg_data);
				REG_S1_A2:  a2_q[0] <= signed'(cfg_data);
				REG_S2_B0:  b0_q[1] <= signed'(cfg_data);
				REG_S2_A1:  a1_q[1] <= signed'(cfg_data);
				REG_S2_A2:  a2_q[1] <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// datapath control
	always_comb begin
		ctrl.load = in_acc && en_q;
		ctrl.op   = (state_q == ST_BUSY) ? step_q : OP_IDLE;
		ctrl.sec  = sec_q;
		ctrl.clr[0] = cfg_we && (cfg_index inside {[REG_S1_B0:REG_S1_A2]});
		ctrl.clr[1] = cfg_we && (cfg_index inside {[REG_S2_B0:REG_S2_A2]});
	end

	// coefficient for the multiplier step
	always_comb begin
		case (step_q)
			OP_MUL_A1: coef = a1_q[sec_q];
			OP_MUL_A2: coef = a2_q[sec_q];
			default:   coef = b0_q[sec_q];
		endcase
	end

	bwlp_datapath #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.coef     (coef),
		.sample_in(sample_in),
		.y_sample (dp_y)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= OP_MUL_B0;
			sec_q       <= 1'b0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pass_q  <= !en_q;
						step_q  <= OP_MUL_B0;
						sec_q   <= 1'b0;
						state_q <= en_q ? ST_BUSY : ST_DONE;
					end
				end
				ST_BUSY: begin
					case (step_q)
						OP_MUL_B0: step_q <= OP_Y;
						OP_Y:      step_q <= OP_MUL_A1;
						OP_MUL_A1: step_q <= OP_N1;
						OP_N1:     step_q <= OP_MUL_A2;
						OP_MUL_A2: step_q <= OP_N2;
						default: begin
							step_q <= OP_MUL_B0;
							sec_q  <= !sec_q;
							if (sec_q) begin
								state_q <= ST_DONE;
							end
						end
					endcase
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bypass sample and output register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pass_sample_q <= sample_in;
		end
		if (state_q == ST_DONE && out_free) begin
			sample_out_q <= pass_q ? pass_sample_q : dp_y;
		end
	end

`ifndef NO_ASSERTIONS
	a_start_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && en_q) |=> (state_q == ST_BUSY && step_q == OP_MUL_B0 && !sec_q))
		else $error("filtered item did not start at the first step of section one");

	a_sec_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_BUSY) |-> !sec_q)
		else $error("section select left set outside the busy state");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result presented without finishing an item");
`endif

endmodule

@@ rtl/bwlp_datapath.sv @@
module bwlp_datapath #(
	parameter int SAMPLE_WIDTH = bwlp_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bwlp_pkg::ctrl_t                       ctrl,
	input  logic signed [bwlp_pkg::COEF_W-1:0]    coef,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
	output logic signed [SAMPLE_WIDTH-1:0]        y_sample
);
	import bwlp_pkg::*;

	localparam int DATA_FRAC  = DATA_W - SAMPLE_WIDTH;
	localparam int PROD_SHIFT = COEF_FRAC + DATA_FRAC - ACC_FRAC;
	localparam int Y_SHIFT    = ACC_FRAC - DATA_FRAC;

	logic signed [DATA_W-1:0] u_q;
	logic signed [DATA_W-1:0] y_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [SUM_W-1:0]  pb1_q;
	logic signed [SUM_W-1:0]  pb2_q;
	logic signed [ACC_W-1:0]  acc1_q [2];
	logic signed [ACC_W-1:0]  acc2_q [2];

	logic signed [DATA_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0]  p_sh;
	logic signed [SUM_W-1:0]  yacc;
	logic signed [SUM_W-1:0]  y_wide;
	logic signed [SUM_W-1:0]  n1;
	logic signed [SUM_W-1:0]  n2;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-ACC_W:0] top;
		top = x[SUM_W-1:ACC_W-1];
		if (&top || ~|top)
			return x[ACC_W-1:0];
		return x[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-DATA_W:0] top;
		top = x[SUM_W-1:DATA_W-1];
		if (&top || ~|top)
			return x[DATA_W-1:0];
		return x[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	// shared multiplier, operand is the section input or the section output
	assign mul_b = (ctrl.op == OP_MUL_B0) ? u_q : y_q;
	assign prod  = coef * mul_b;

	// product scaled down to accumulator fraction bits
	assign p_sh   = SUM_W'(p_q >>> PROD_SHIFT);
	assign yacc   = p_sh + SUM_W'(acc1_q[ctrl.sec]);
	assign y_wide = yacc >>> Y_SHIFT;
	assign n1     = pb2_q - p_sh + SUM_W'(acc2_q[ctrl.sec]);
	assign n2     = pb1_q - p_sh;

	// operand and product registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			u_q <= DATA_W'(sample_in) <<< DATA_FRAC;
		end else if (ctrl.op == OP_N2 && !ctrl.sec) begin
			u_q <= y_q;
		end
		if (ctrl.op == OP_MUL_B0 || ctrl.op == OP_MUL_A1 || ctrl.op == OP_MUL_A2) begin
			p_q <= prod;
		end
		if (ctrl.op == OP_Y) begin
			pb1_q <= p_sh;
			pb2_q <= SUM_W'(p_q >>> (PROD_SHIFT - 1));
			y_q   <= sat_data(y_wide);
		end
	end

	// section accumulators, cleared by reset or a coefficient write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc1_q[0] <= '0;
			acc1_q[1] <= '0;
			acc2_q[0] <= '0;
			acc2_q[1] <= '0;
		end else begin
			for (int s = 0; s < 2; s++) begin
				if (ctrl.clr[s]) begin
					acc1_q[s] <= '0;
					acc2_q[s] <= '0;
				end
			end
			if (ctrl.op == OP_N1) begin
				acc1_q[ctrl.sec] <= sat_acc(n1);
			end
			if (ctrl.op == OP_N2) begin
				acc2_q[ctrl.sec] <= sat_acc(n2);
			end
		end
	end

	// section output floored to whole sample
	assign y_sample = y_q[DATA_W-1 -: SAMPLE_WIDTH];

endmodule

@@ bench/tb_butterworth_lowpass_biquad_cascade_top.sv @@
`timescale 1ns / 1ps

module tb_butterworth_lowpass_biquad_cascade_top;
	import bwlp_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int DFRAC = DATA_W - SW;
	localparam int PSH = COEF_FRAC + DFRAC - ACC_FRAC;
	localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint DATA_HI = 64'sd2147483647;
	localparam longint DATA_LO = -DATA_HI - 1;
	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam real Q_LOW = 0.54120;
	localparam real Q_HIGH = 1.30656;
	localparam real FC_TOP = 21600.0;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] sample_out;

	butterworth_lowpass_biquad_cascade_top #(
		.SAMPLE_WIDTH(SW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out)
	);

	// 8 ns clock
	initial begin
		forever #4 clk = ~clk;
	end

	// filter model: registers and accumulators, section 0 then section 1
	bit filt_on = 1'b0;
	logic signed [COEF_W-1:0] b0_c [2] = '{0, 0};
	logic signed [COEF_W-1:0] a1_c [2] = '{0, 0};
	logic signed [COEF_W-1:0] a2_c [2] = '{0, 0};
	longint acc1_s [2] = '{0, 0};
	longint acc2_s [2] = '{0, 0};

	typedef struct {
		logic signed [SW-1:0] sample;
		int unsigned seq;
	} filtered_t;

	logic signed [SW-1:0] samples_to_send [$];
	filtered_t filtered_due [$];
	filtered_t due_item;

	int unsigned items_queued = 0;
	int unsigned sent_cnt = 0;
	int unsigned recv_cnt = 0;
	int unsigned filtered_items = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned send_gap = 0;
	int unsigned hold_left = 0;
	bit quiet_phase = 1'b0;

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// one transposed direct form II low-pass section, b1 = 2*b0 and b2 = b0
	function automatic longint biquad_stage(int sec, longint u);
		longint ff, y, n1, n2;
		ff = longint'(b0_c[sec]) * u;
		y = clip(((ff >>> PSH) + acc1_s[sec]) >>> (ACC_FRAC - DFRAC), DATA_LO, DATA_HI);
		n1 = (ff >>> (PSH - 1)) - ((longint'(a1_c[sec]) * y) >>> PSH) + acc2_s[sec];
		n2 = (ff >>> PSH) - ((longint'(a2_c[sec]) * y) >>> PSH);
		acc1_s[sec] = clip(n1, ACC_LO, ACC_HI);
		acc2_s[sec] = clip(n2, ACC_LO, ACC_HI);
		return y;
	endfunction

	function automatic logic signed [SW-1:0] predict_sample(logic signed [SW-1:0] x);
		longint y;
		if (!filt_on) return x;
		filtered_items++;
		y = biquad_stage(0, longint'(x) <<< DFRAC);
		y = biquad_stage(1, y);
		return SW'(y >>> DFRAC);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_ENABLE: filt_on = val[0];
			REG_S1_B0: b0_c[0] = val;
			REG_S1_A1: a1_c[0] = val;
			REG_S1_A2: a2_c[0] = val;
			REG_S2_B0: b0_c[1] = val;
			REG_S2_A1: a1_c[1] = val;
			REG_S2_A2: a2_c[1] = val;
			default: ;
		endcase
		// a coefficient write restarts its own section
		if (idx == REG_S1_B0 || idx == REG_S1_A1 || idx == REG_S1_A2) begin
			acc1_s[0] = 0;
			acc2_s[0] = 0;
		end else if (idx == REG_S2_B0 || idx == REG_S2_A1 || idx == REG_S2_A2) begin
			acc1_s[1] = 0;
			acc2_s[1] = 0;
		end
	endfunction

	// mostly short gaps, some long ones, none in quiet phases
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99);
		if (quiet_phase || r < 45) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(20, 4);
		return $urandom_range(80, 30);
	endfunction

	// held values give step runs; full scale drives saturation
	function automatic logic signed [SW-1:0] pick_sample(logic signed [SW-1:0] prev);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 25) return prev;
		if (r < 33) return SMAX;
		if (r < 41) return SMIN;
		if (r < 56) return SW'(int'($urandom_range(255)) - 128);
		return SW'($urandom());
	endfunction

	function automatic logic [COEF_W-1:0] extreme_coef();
		case ($urandom_range(3))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] to_q30(real r);
		real v;
		v = r * 1073741824.0;
		if (v > 2147483647.0) v = 2147483647.0;
		if (v < -2147483648.0) v = -2147483648.0;
		return COEF_W'($rtoi(v));
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		// keep the log short when everything goes wrong
		if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_reg(idx, val);
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_section(int sec, logic [COEF_W-1:0] b0, logic [COEF_W-1:0] a1,
			logic [COEF_W-1:0] a2);
		if (sec == 0) begin
			write_reg(REG_S1_B0, b0);
			write_reg(REG_S1_A1, a1);
			write_reg(REG_S1_A2, a2);
		end else begin
			write_reg(REG_S2_B0, b0);
			write_reg(REG_S2_A1, a1);
			write_reg(REG_S2_A2, a2);
		end
	endtask

	// bilinear low-pass section at 48 kHz
	task automatic load_butterworth(int sec, real fc, real q);
		real w0, cs, alpha, a0;
		w0 = 2.0 * 3.14159265358979 * fc / 48000.0;
		cs = $cos(w0);
		alpha = $sin(w0) / (2.0 * q);
		a0 = 1.0 + alpha;
		set_section(sec, to_q30((1.0 - cs) / (2.0 * a0)), to_q30(-2.0 * cs / a0),
			to_q30((1.0 - alpha) / a0));
	endtask

	task automatic queue_sample(logic signed [SW-1:0] x);
		samples_to_send.push_back(x);
		items_queued++;
	endtask

	// idle once every queued item has come back, then let the pipeline settle
	task automatic wait_idle();
		do @(posedge clk);
		while (recv_cnt < items_queued);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sample driver: one item at a time, random gaps between items
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				filtered_due.push_back('{predict_sample(sample_in), sent_cnt});
				sent_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (samples_to_send.size() > 0) begin
					in_valid <= 1'b1;
					sample_in <= samples_to_send.pop_front();
					send_gap = idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: check each item, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_due.size() == 0) begin
					report_mismatch($sformatf("output %0d with nothing expected", sample_out));
				end else begin
					due_item = filtered_due.pop_front();
					if (sample_out !== due_item.sample)
						report_mismatch($sformatf("item %0d: sample_out %0d, expected %0d",
							due_item.seq, sample_out, due_item.sample));
				end
				recv_cnt++;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
				hold_left = idle_len();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d items back", cycles, recv_cnt,
				items_queued);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus and phase sequencing
	initial begin
		logic signed [SW-1:0] prev;
		int unsigned n;
		int sec;
		prev = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// pass-through after reset: extremes and bit patterns
		queue_sample('0);
		queue_sample(SMAX);
		queue_sample(SMIN);
		queue_sample(-1);
		queue_sample(1);
		queue_sample(SW'(24'h555555));
		queue_sample(SW'(24'haaaaaa));
		wait_idle();

		// 1 kHz cascade: full-scale steps up and down to reach saturation
		load_butterworth(0, 1000.0, Q_LOW);
		load_butterworth(1, 1000.0, Q_HIGH);
		write_reg(REG_ENABLE, 32'h1);
		repeat (8) queue_sample(SMAX);
		repeat (6) queue_sample(SMIN);
		queue_sample('0);
		queue_sample(1);
		queue_sample(-1);

		// random phases, each with its own register setting
		for (int p = 0; p < 12; p++) begin
			wait_idle();
			quiet_phase = ($urandom_range(3) == 0);
			case (p % 6)
				0: begin
					load_butterworth(0, real'($urandom_range(21600, 100)), Q_LOW);
					load_butterworth(1, real'($urandom_range(21600, 100)), Q_HIGH);
					write_reg(REG_UNUSED, $urandom());
					write_reg(REG_ENABLE, $urandom() | 32'h1);
				end
				1: begin
					set_section(0, extreme_coef(), extreme_coef(), extreme_coef());
					set_section(1, extreme_coef(), extreme_coef(), extreme_coef());
					write_reg(REG_ENABLE, 32'h1);
				end
				2: begin
					set_section(0, $urandom(), $urandom(), $urandom());
					set_section(1, $urandom(), $urandom(), $urandom());
					write_reg(REG_UNUSED, $urandom());
				end
				3: begin
					// bypass keeps the accumulators as they are
					write_reg(REG_ENABLE, $urandom() & ~32'h1);
				end
				4: begin
					load_butterworth(0, FC_TOP, Q_LOW);
					load_butterworth(1, FC_TOP, Q_HIGH);
					write_reg(REG_ENABLE, 32'h1);
				end
				default: begin
					// restart one section, the other carries on
					sec = $urandom_range(1);
					load_butterworth(sec, real'($urandom_range(21600, 100)),
						(sec == 0) ? Q_LOW : Q_HIGH);
					write_reg(REG_ENABLE, $urandom() | 32'h1);
				end
			endcase
			n = $urandom_range(50, 30);
			repeat (n) begin
				prev = pick_sample(prev);
				queue_sample(prev);
			end
		end

		wait_idle();
		while (filtered_due.size() > 0) begin
			due_item = filtered_due.pop_front();
			report_mismatch($sformatf("item %0d never came out", due_item.seq));
		end
		$display("sent %0d samples, %0d of them through the cascade, over %0d register writes",
			sent_cnt, filtered_items, reg_writes);
		$display("covered bypass, cutoffs up to 21.6 kHz, extreme and random coefficients");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bwlp_pkg.sv
rtl/bwlp_datapath.sv
rtl/butterworth_lowpass_biquad_cascade_top.sv
bench/tb_butterworth_lowpass_biquad_cascade_top.sv
